@@ hdl/gmbm_pkg.sv @@
// Shared constants, codes, types and address helpers of the GF(2) matrix BM base case.
package gmbm_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 16;
  localparam int WORDS     = 4;
  localparam int WORD_BITS = 64;
  localparam int LEN_MAX   = WORDS * WORD_BITS;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int WSEL_W = 2;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int EA_W   = ROW_W + COL_W + WSEL_W;
  localparam int PA_W   = 2 * COL_W + WSEL_W;

  localparam logic [2:0] MODE_WR_E   = 3'd0;
  localparam logic [2:0] MODE_WR_DEG = 3'd1;
  localparam logic [2:0] MODE_RUN    = 3'd2;
  localparam logic [2:0] MODE_RD_P   = 3'd3;
  localparam logic [2:0] MODE_RD_COL = 3'd4;

  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_PWORD = 2'd1;
  localparam logic [1:0] KIND_COL   = 2'd2;

  localparam logic [1:0] ST_FULL  = 2'd0;
  localparam logic [1:0] ST_EARLY = 2'd1;
  localparam logic [1:0] ST_NOPIV = 2'd2;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_LEN  = 2'd2;

  localparam logic [8:0] LD_MAX = 9'd511;

  typedef enum logic [4:0] {
    S_IDLE, S_RDWAIT, S_COPY_RD, S_COPY_WR, S_INIT_P, S_STEP, S_ROW,
    S_SCAN_RD, S_SCAN_CHK, S_PIV, S_COLK, S_XW_RD, S_XW_WR, S_XP_RD,
    S_XP_WR, S_SHW_RD, S_SHW_WR, S_SHP_RD, S_SHP_WR, S_ROW_END, S_STEP_END
  } state_t;

  typedef enum logic [1:0] {WS_LOAD, WS_XOR, WS_SHIFT} wsrc_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [1:0]  word;
    logic [63:0] data;
    logic [31:0] degree_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [8:0]  steps;
    logic [63:0] word_out;
    logic [31:0] column_degree;
    logic [8:0]  local_degree;
    logic [31:0] zero_run;
    logic [31:0] total_steps;
  } res_t;

  typedef struct packed {
    logic             e_we;
    logic             deg_we;
    logic             col_rd;
    logic             p_rd;
    logic             p_out;
    logic             run_out;
    logic [1:0]       run_status;
    logic [8:0]       steps;
    logic             run_start;
    logic [4:0]       b;
    logic [2:0]       w;
    logic [EA_W-1:0]  e_ra;
    logic [EA_W-1:0]  wk_ra;
    logic [EA_W-1:0]  wk_rb;
    logic [EA_W-1:0]  wk_wa;
    logic             wk_we;
    wsrc_t            wk_src;
    logic [PA_W-1:0]  p_ra;
    logic [PA_W-1:0]  p_rb;
    logic [PA_W-1:0]  p_wa;
    logic             p_we;
    wsrc_t            p_src;
    logic             p_one;
    logic             carry_last;
    logic             scan_clr;
    logic             scan_chk;
    logic [COL_W-1:0] jsel;
    logic [BIT_W-1:0] bsel;
    logic             piv_mark;
    logic             k_mark;
    logic             row_end;
    logic             step_clr;
    logic             step_end;
  } cmd_t;

  typedef struct packed {
    logic                found;
    logic [COL_W-1:0]    pv;
    logic [MAX_COLS-1:0] mask;
    logic                changed;
    logic                out_free;
  } sts_t;

  function automatic logic [EA_W-1:0] wa(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                         logic [WSEL_W-1:0] s);
    return {r, c, s};
  endfunction

  function automatic logic [PA_W-1:0] pa(logic [COL_W-1:0] r, logic [COL_W-1:0] c,
                                         logic [WSEL_W-1:0] s);
    return {r, c, s};
  endfunction

endpackage

@@ hdl/gmbm_req_if.sv @@
// Request channel: valid/ready handshake with the input item fields.
interface gmbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  row;
  logic [3:0]  col;
  logic [1:0]  word;
  logic [63:0] data;
  logic [31:0] degree_in;
  modport source (output valid, mode, row, col, word, data, degree_in, input ready);
  modport sink (input valid, mode, row, col, word, data, degree_in, output ready);
endinterface

@@ hdl/gmbm_res_if.sv @@
// Result channel: valid/ready handshake with the result item fields.
interface gmbm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [8:0]  steps;
  logic [63:0] word_out;
  logic [31:0] column_degree;
  logic [8:0]  local_degree;
  logic [31:0] zero_run;
  logic [31:0] total_steps;
  modport source (output valid, kind, status, steps, word_out, column_degree,
                  local_degree, zero_run, total_steps, input ready);
  modport sink (input valid, kind, status, steps, word_out, column_degree,
                local_degree, zero_run, total_steps, output ready);
endinterface

@@ hdl/gmbm_ctrl.sv @@
// Controller: configuration registers, request decode and the run sequencer.
module gmbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data,
  input  logic             req_valid,
  input  gmbm_pkg::req_t   req,
  input  gmbm_pkg::sts_t   sts,
  output logic             req_ready,
  output gmbm_pkg::cmd_t   cmd
);

  gmbm_pkg::state_t state, state_next;
  logic [3:0] num_rows;
  logic [4:0] num_cols;
  logic [8:0] length_bits;
  logic [8:0] e_cnt, e_cnt_next;
  logic [3:0] i_cnt, i_cnt_next;
  logic [4:0] j_cnt, j_cnt_next;
  logic [4:0] l_cnt, l_cnt_next;
  logic [1:0] s_cnt, s_cnt_next;
  logic [3:0] m_r, m_r_next;
  logic [4:0] b_r, b_r_next;
  logic [8:0] len_r, len_r_next;
  logic [2:0] w_r, w_r_next;
  logic [3:0] m_eff;
  logic [4:0] b_eff;
  logic [8:0] len_eff;
  logic [2:0] w_eff;
  logic       s_last;
  logic [gmbm_pkg::WSEL_W-1:0] wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows    <= 4'd1;
      num_cols    <= 5'd2;
      length_bits <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        gmbm_pkg::CFG_ROWS: num_rows    <= cfg_data[3:0];
        gmbm_pkg::CFG_COLS: num_cols    <= cfg_data[4:0];
        gmbm_pkg::CFG_LEN:  length_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmbm_pkg::S_IDLE;
      e_cnt <= '0;
      i_cnt <= '0;
      j_cnt <= '0;
      l_cnt <= '0;
      s_cnt <= '0;
      m_r   <= '0;
      b_r   <= '0;
      len_r <= '0;
      w_r   <= 3'd1;
    end else begin
      state <= state_next;
      e_cnt <= e_cnt_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      l_cnt <= l_cnt_next;
      s_cnt <= s_cnt_next;
      m_r   <= m_r_next;
      b_r   <= b_r_next;
      len_r <= len_r_next;
      w_r   <= w_r_next;
    end
  end

  assign m_eff   = (int'(num_rows) > gmbm_pkg::MAX_ROWS) ? 4'(gmbm_pkg::MAX_ROWS) : num_rows;
  assign b_eff   = (int'(num_cols) > gmbm_pkg::MAX_COLS) ? 5'(gmbm_pkg::MAX_COLS) : num_cols;
  assign len_eff = (int'(length_bits) > gmbm_pkg::LEN_MAX) ? 9'(gmbm_pkg::LEN_MAX)
                                                            : length_bits;
  assign w_eff   = (len_eff == '0) ? 3'd1
                 : 3'((10'(len_eff) + 10'(gmbm_pkg::WORD_BITS - 1)) >> gmbm_pkg::BIT_W);
  assign s_last  = ({1'b0, s_cnt} == (w_r - 3'd1));
  assign wp      = e_cnt[gmbm_pkg::BIT_W +: gmbm_pkg::WSEL_W];

  always_comb begin
    state_next = state;
    e_cnt_next = e_cnt;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    l_cnt_next = l_cnt;
    s_cnt_next = s_cnt;
    m_r_next   = m_r;
    b_r_next   = b_r;
    len_r_next = len_r;
    w_r_next   = w_r;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.b      = b_eff;
    cmd.w      = w_eff;
    cmd.jsel   = j_cnt[gmbm_pkg::COL_W-1:0];
    cmd.bsel   = e_cnt[gmbm_pkg::BIT_W-1:0];
    cmd.steps  = e_cnt;
    case (state)
      gmbm_pkg::S_IDLE: begin
        req_ready = sts.out_free;
        cmd.p_ra  = gmbm_pkg::pa(req.row, req.col, req.word);
        if (req_valid && sts.out_free) begin
          case (req.mode)
            gmbm_pkg::MODE_WR_E:   cmd.e_we = (int'(req.row) < gmbm_pkg::MAX_ROWS);
            gmbm_pkg::MODE_WR_DEG: cmd.deg_we = 1'b1;
            gmbm_pkg::MODE_RUN: begin
              cmd.run_start = 1'b1;
              m_r_next   = m_eff;
              b_r_next   = b_eff;
              len_r_next = len_eff;
              w_r_next   = w_eff;
              l_cnt_next = '0;
              j_cnt_next = '0;
              s_cnt_next = '0;
              state_next = gmbm_pkg::S_COPY_RD;
            end
            gmbm_pkg::MODE_RD_P: begin
              cmd.p_rd   = 1'b1;
              state_next = gmbm_pkg::S_RDWAIT;
            end
            gmbm_pkg::MODE_RD_COL: cmd.col_rd = 1'b1;
            default: ;
          endcase
        end
      end
      gmbm_pkg::S_RDWAIT: begin
        cmd.p_out  = 1'b1;
        state_next = gmbm_pkg::S_IDLE;
      end
      gmbm_pkg::S_COPY_RD: begin
        if (l_cnt == {1'b0, m_r} || b_r == '0) begin
          l_cnt_next = '0;
          j_cnt_next = '0;
          s_cnt_next = '0;
          state_next = gmbm_pkg::S_INIT_P;
        end else begin
          cmd.e_ra   = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0],
                                    j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
          state_next = gmbm_pkg::S_COPY_WR;
        end
      end
      gmbm_pkg::S_COPY_WR: begin
        cmd.wk_we  = 1'b1;
        cmd.wk_src = gmbm_pkg::WS_LOAD;
        cmd.wk_wa  = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0],
                                  j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
        if (s_last) begin
          s_cnt_next = '0;
          if (j_cnt == b_r - 5'd1) begin
            j_cnt_next = '0;
            l_cnt_next = l_cnt + 5'd1;
          end else begin
            j_cnt_next = j_cnt + 5'd1;
          end
        end else begin
          s_cnt_next = s_cnt + 2'd1;
        end
        state_next = gmbm_pkg::S_COPY_RD;
      end
      gmbm_pkg::S_INIT_P: begin
        if (l_cnt == b_r) begin
          e_cnt_next = '0;
          state_next = gmbm_pkg::S_STEP;
        end else begin
          cmd.p_we  = 1'b1;
          cmd.p_src = gmbm_pkg::WS_LOAD;
          cmd.p_one = (l_cnt == j_cnt) && (s_cnt == '0);
          cmd.p_wa  = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0],
                                   j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
          if (s_last) begin
            s_cnt_next = '0;
            if (j_cnt == b_r - 5'd1) begin
              j_cnt_next = '0;
              l_cnt_next = l_cnt + 5'd1;
            end else begin
              j_cnt_next = j_cnt + 5'd1;
            end
          end else begin
            s_cnt_next = s_cnt + 2'd1;
          end
        end
      end
      gmbm_pkg::S_STEP: begin
        if (e_cnt == len_r) begin
          cmd.run_out    = 1'b1;
          cmd.run_status = gmbm_pkg::ST_FULL;
          state_next     = gmbm_pkg::S_IDLE;
        end else begin
          cmd.step_clr = 1'b1;
          i_cnt_next   = '0;
          state_next   = gmbm_pkg::S_ROW;
        end
      end
      gmbm_pkg::S_ROW: begin
        if (i_cnt == m_r) begin
          state_next = gmbm_pkg::S_STEP_END;
        end else begin
          cmd.scan_clr = 1'b1;
          j_cnt_next   = '0;
          state_next   = gmbm_pkg::S_SCAN_RD;
        end
      end
      gmbm_pkg::S_SCAN_RD: begin
        if (j_cnt == b_r) begin
          state_next = gmbm_pkg::S_PIV;
        end else begin
          cmd.wk_ra  = gmbm_pkg::wa(i_cnt[gmbm_pkg::ROW_W-1:0],
                                    j_cnt[gmbm_pkg::COL_W-1:0], wp);
          state_next = gmbm_pkg::S_SCAN_CHK;
        end
      end
      gmbm_pkg::S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        j_cnt_next   = j_cnt + 5'd1;
        state_next   = gmbm_pkg::S_SCAN_RD;
      end
      gmbm_pkg::S_PIV: begin
        if (!sts.found) begin
          cmd.run_out    = 1'b1;
          cmd.run_status = gmbm_pkg::ST_NOPIV;
          state_next     = gmbm_pkg::S_IDLE;
        end else begin
          cmd.piv_mark = 1'b1;
          j_cnt_next   = '0;
          state_next   = gmbm_pkg::S_COLK;
        end
      end
      gmbm_pkg::S_COLK: begin
        l_cnt_next = '0;
        s_cnt_next = '0;
        if (j_cnt == b_r) begin
          state_next = gmbm_pkg::S_SHW_RD;
        end else if (j_cnt[gmbm_pkg::COL_W-1:0] == sts.pv ||
                     !sts.mask[j_cnt[gmbm_pkg::COL_W-1:0]]) begin
          j_cnt_next = j_cnt + 5'd1;
        end else begin
          cmd.k_mark = 1'b1;
          state_next = gmbm_pkg::S_XW_RD;
        end
      end
      gmbm_pkg::S_XW_RD: begin
        if (l_cnt == {1'b0, m_r}) begin
          l_cnt_next = '0;
          s_cnt_next = '0;
          state_next = gmbm_pkg::S_XP_RD;
        end else begin
          cmd.wk_ra  = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0], sts.pv, s_cnt);
          cmd.wk_rb  = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0],
                                    j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
          state_next = gmbm_pkg::S_XW_WR;
        end
      end
      gmbm_pkg::S_XW_WR: begin
        cmd.wk_we  = 1'b1;
        cmd.wk_src = gmbm_pkg::WS_XOR;
        cmd.wk_wa  = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0],
                                  j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
        if (s_last) begin
          s_cnt_next = '0;
          l_cnt_next = l_cnt + 5'd1;
        end else begin
          s_cnt_next = s_cnt + 2'd1;
        end
        state_next = gmbm_pkg::S_XW_RD;
      end
      gmbm_pkg::S_XP_RD: begin
        if (l_cnt == b_r) begin
          j_cnt_next = j_cnt + 5'd1;
          state_next = gmbm_pkg::S_COLK;
        end else begin
          cmd.p_ra   = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0], sts.pv, s_cnt);
          cmd.p_rb   = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0],
                                    j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
          state_next = gmbm_pkg::S_XP_WR;
        end
      end
      gmbm_pkg::S_XP_WR: begin
        cmd.p_we  = 1'b1;
        cmd.p_src = gmbm_pkg::WS_XOR;
        cmd.p_wa  = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0],
                                 j_cnt[gmbm_pkg::COL_W-1:0], s_cnt);
        if (s_last) begin
          s_cnt_next = '0;
          l_cnt_next = l_cnt + 5'd1;
        end else begin
          s_cnt_next = s_cnt + 2'd1;
        end
        state_next = gmbm_pkg::S_XP_RD;
      end
      gmbm_pkg::S_SHW_RD: begin
        if (l_cnt == {1'b0, m_r}) begin
          l_cnt_next = '0;
          s_cnt_next = '0;
          state_next = gmbm_pkg::S_SHP_RD;
        end else begin
          cmd.wk_ra  = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0], sts.pv, s_cnt);
          state_next = gmbm_pkg::S_SHW_WR;
        end
      end
      gmbm_pkg::S_SHW_WR: begin
        cmd.wk_we      = 1'b1;
        cmd.wk_src     = gmbm_pkg::WS_SHIFT;
        cmd.carry_last = s_last;
        cmd.wk_wa      = gmbm_pkg::wa(l_cnt[gmbm_pkg::ROW_W-1:0], sts.pv, s_cnt);
        if (s_last) begin
          s_cnt_next = '0;
          l_cnt_next = l_cnt + 5'd1;
        end else begin
          s_cnt_next = s_cnt + 2'd1;
        end
        state_next = gmbm_pkg::S_SHW_RD;
      end
      gmbm_pkg::S_SHP_RD: begin
        if (l_cnt == b_r) begin
          state_next = gmbm_pkg::S_ROW_END;
        end else begin
          cmd.p_ra   = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0], sts.pv, s_cnt);
          state_next = gmbm_pkg::S_SHP_WR;
        end
      end
      gmbm_pkg::S_SHP_WR: begin
        cmd.p_we       = 1'b1;
        cmd.p_src      = gmbm_pkg::WS_SHIFT;
        cmd.carry_last = s_last;
        cmd.p_wa       = gmbm_pkg::pa(l_cnt[gmbm_pkg::COL_W-1:0], sts.pv, s_cnt);
        if (s_last) begin
          s_cnt_next = '0;
          l_cnt_next = l_cnt + 5'd1;
        end else begin
          s_cnt_next = s_cnt + 2'd1;
        end
        state_next = gmbm_pkg::S_SHP_RD;
      end
      gmbm_pkg::S_ROW_END: begin
        cmd.row_end = 1'b1;
        i_cnt_next  = i_cnt + 4'd1;
        state_next  = gmbm_pkg::S_ROW;
      end
      gmbm_pkg::S_STEP_END: begin
        cmd.step_end = 1'b1;
        if (!sts.changed) begin
          cmd.run_out    = 1'b1;
          cmd.run_status = gmbm_pkg::ST_EARLY;
          state_next     = gmbm_pkg::S_IDLE;
        end else begin
          e_cnt_next = e_cnt + 9'd1;
          state_next = gmbm_pkg::S_STEP;
        end
      end
      default: state_next = gmbm_pkg::S_IDLE;
    endcase
  end

endmodule

@@ hdl/gmbm_dp.sv @@
// Datapath: E, working and P memories, column registers and the result register.
module gmbm_dp (
  input  logic           clk,
  input  logic           rst,
  input  gmbm_pkg::cmd_t cmd,
  input  gmbm_pkg::req_t req,
  input  logic           res_ready,
  output gmbm_pkg::sts_t sts,
  output logic           res_valid,
  output gmbm_pkg::res_t res
);

  localparam int EDEPTH = 1 << gmbm_pkg::EA_W;
  localparam int PDEPTH = 1 << gmbm_pkg::PA_W;

  logic [63:0] e_mem  [EDEPTH];
  logic [63:0] wk_mem [EDEPTH];
  logic [63:0] p_mem  [PDEPTH];
  logic [63:0] e_rd, wk_rda, wk_rdb, p_rda, p_rdb;
  logic [63:0] wk_wd, p_wd;
  logic        carry;

  logic [31:0] deg [gmbm_pkg::MAX_COLS];
  logic [8:0]  ld  [gmbm_pkg::MAX_COLS];
  logic [31:0] zr  [gmbm_pkg::MAX_COLS];
  logic [1:0]  modf [gmbm_pkg::MAX_COLS];
  logic [gmbm_pkg::MAX_COLS-1:0] mask;
  logic [gmbm_pkg::COL_W-1:0]    pv;
  logic        found;
  logic [31:0] step_total;
  logic        run_done;
  logic [4:0]  b_run;
  logic [2:0]  w_run;
  logic        pok;
  logic        bitv;
  logic [31:0] total_new;
  logic [gmbm_pkg::MAX_COLS-1:0] chg;
  logic        load;
  gmbm_pkg::res_t res_next;

  always_comb begin
    case (cmd.wk_src)
      gmbm_pkg::WS_LOAD:  wk_wd = e_rd;
      gmbm_pkg::WS_XOR:   wk_wd = wk_rda ^ wk_rdb;
      gmbm_pkg::WS_SHIFT: wk_wd = {wk_rda[62:0], carry};
      default:            wk_wd = wk_rda;
    endcase
    case (cmd.p_src)
      gmbm_pkg::WS_LOAD:  p_wd = {63'd0, cmd.p_one};
      gmbm_pkg::WS_XOR:   p_wd = p_rda ^ p_rdb;
      gmbm_pkg::WS_SHIFT: p_wd = {p_rda[62:0], carry};
      default:            p_wd = p_rda;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.e_we)
      e_mem[{req.row[gmbm_pkg::ROW_W-1:0], req.col, req.word}] <= req.data;
    e_rd <= e_mem[cmd.e_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.wk_we)
      wk_mem[cmd.wk_wa] <= wk_wd;
    wk_rda <= wk_mem[cmd.wk_ra];
    wk_rdb <= wk_mem[cmd.wk_rb];
  end

  always_ff @(posedge clk) begin
    if (cmd.p_we)
      p_mem[cmd.p_wa] <= p_wd;
    p_rda <= p_mem[cmd.p_ra];
    p_rdb <= p_mem[cmd.p_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if ((cmd.wk_we && cmd.wk_src == gmbm_pkg::WS_SHIFT) ||
                 (cmd.p_we && cmd.p_src == gmbm_pkg::WS_SHIFT)) begin
      carry <= cmd.carry_last ? 1'b0
             : (cmd.wk_we ? wk_rda[63] : p_rda[63]);
    end
  end

  assign bitv = wk_rda[cmd.bsel];

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      found <= 1'b0;
      mask  <= '0;
    end else if (cmd.scan_chk) begin
      mask[cmd.jsel] <= bitv;
      if (bitv && (!found || deg[cmd.jsel] < deg[pv])) begin
        found <= 1'b1;
        pv    <= cmd.jsel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < gmbm_pkg::MAX_COLS; j++) begin
        deg[j]  <= '0;
        ld[j]   <= '0;
        zr[j]   <= '0;
        modf[j] <= '0;
      end
      step_total <= '0;
      run_done   <= 1'b0;
      b_run      <= '0;
      w_run      <= 3'd1;
    end else begin
      if (cmd.deg_we)
        deg[req.col] <= req.degree_in;
      if (cmd.run_start) begin
        run_done <= 1'b1;
        b_run    <= cmd.b;
        w_run    <= cmd.w;
        for (int j = 0; j < gmbm_pkg::MAX_COLS; j++)
          if (j < int'(cmd.b))
            ld[j] <= '0;
      end
      if (cmd.step_clr)
        for (int j = 0; j < gmbm_pkg::MAX_COLS; j++)
          modf[j] <= '0;
      if (cmd.piv_mark)
        modf[pv][1] <= 1'b1;
      if (cmd.k_mark) begin
        modf[cmd.jsel][0] <= 1'b1;
        if (ld[pv] > ld[cmd.jsel])
          ld[cmd.jsel] <= ld[pv];
      end
      if (cmd.row_end) begin
        deg[pv] <= deg[pv] + 32'd1;
        if (ld[pv] < gmbm_pkg::LD_MAX)
          ld[pv] <= ld[pv] + 9'd1;
      end
      if (cmd.step_end)
        for (int j = 0; j < gmbm_pkg::MAX_COLS; j++)
          if (j < int'(b_run))
            zr[j] <= (modf[j] != '0) ? 32'd0 : zr[j] + 32'd1;
      if (cmd.run_out)
        step_total <= total_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_rd)
      pok <= run_done && ({1'b0, req.row} < b_run) && ({1'b0, req.col} < b_run)
             && ({1'b0, req.word} < w_run);
  end

  assign total_new = step_total + {23'd0, cmd.steps};

  always_comb begin
    for (int j = 0; j < gmbm_pkg::MAX_COLS; j++)
      chg[j] = modf[j][0];
  end

  assign load = cmd.col_rd || cmd.p_out || cmd.run_out;

  always_ff @(posedge clk) begin
    if (rst)
      res_valid <= 1'b0;
    else if (load)
      res_valid <= 1'b1;
    else if (res_ready)
      res_valid <= 1'b0;
  end

  always_comb begin
    res_next = '0;
    if (cmd.col_rd) begin
      res_next.kind          = gmbm_pkg::KIND_COL;
      res_next.column_degree = deg[req.col];
      res_next.local_degree  = ld[req.col];
      res_next.zero_run      = zr[req.col];
      res_next.total_steps   = step_total;
    end else if (cmd.p_out) begin
      res_next.kind        = gmbm_pkg::KIND_PWORD;
      res_next.word_out    = pok ? p_rda : 64'd0;
      res_next.total_steps = step_total;
    end else begin
      res_next.kind        = gmbm_pkg::KIND_RUN;
      res_next.status      = cmd.run_status;
      res_next.steps       = cmd.steps;
      res_next.total_steps = total_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      res <= res_next;
  end

  assign sts.found    = found;
  assign sts.pv       = pv;
  assign sts.mask     = mask;
  assign sts.changed  = |chg;
  assign sts.out_free = !res_valid || res_ready;

endmodule

@@ hdl/gf2_matrix_berlekamp_massey_base.sv @@
// Top level: GF(2) matrix Berlekamp-Massey quadratic base case.
// Write requests produce no result; a column status read loads the result register when
// taken, and a P word read first passes the P memory read register and S_RDWAIT.
// A run copies E into the working memory and sets P to the identity, then per step and
// row scans for a pivot, eliminates the other columns that hold the bit and shifts the pivot.
// Synchronous reset clears config to defaults, degrees, counters and the total; E is unset.
module gf2_matrix_berlekamp_massey_base (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  gmbm_req_if.sink   req,
  gmbm_res_if.source res
);

  gmbm_pkg::req_t req_p;
  gmbm_pkg::res_t res_p;
  gmbm_pkg::cmd_t cmd;
  gmbm_pkg::sts_t sts;

  assign req_p.mode      = req.mode;
  assign req_p.row       = req.row;
  assign req_p.col       = req.col;
  assign req_p.word      = req.word;
  assign req_p.data      = req.data;
  assign req_p.degree_in = req.degree_in;

  gmbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req.valid),
    .req       (req_p),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  gmbm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req_p),
    .res_ready (res.ready),
    .sts       (sts),
    .res_valid (res.valid),
    .res       (res_p)
  );

  assign res.kind          = res_p.kind;
  assign res.status        = res_p.status;
  assign res.steps         = res_p.steps;
  assign res.word_out      = res_p.word_out;
  assign res.column_degree = res_p.column_degree;
  assign res.local_degree  = res_p.local_degree;
  assign res.zero_run      = res_p.zero_run;
  assign res.total_steps   = res_p.total_steps;

endmodule

@@ hdl/gmbm_checker.sv @@
// Port-level checker for the matrix BM base case, bound to the top level.
module gmbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [2:0] req_mode,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [1:0] res_status,
  input logic [8:0] res_steps,
  input logic [63:0] res_word_out
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == gmbm_pkg::MODE_RUN |=> !req_ready)
    else $error("request taken during run");

  a_run_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == gmbm_pkg::KIND_RUN |-> res_word_out == 64'd0 &&
    (res_status == gmbm_pkg::ST_FULL || res_status == gmbm_pkg::ST_EARLY ||
     res_status == gmbm_pkg::ST_NOPIV))
    else $error("bad run result");

  a_steps_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_steps[8] |-> res_steps[7:0] == 8'd0)
    else $error("step count beyond length limit");

endmodule

bind gf2_matrix_berlekamp_massey_base gmbm_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_mode     (req.mode),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_kind     (res.kind),
  .res_status   (res.status),
  .res_steps    (res.steps),
  .res_word_out (res.word_out)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the GF(2) matrix Berlekamp-Massey base case: random and directed requests.
module testbench;

  localparam int WATCHDOG = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = gmbm_pkg::CFG_ROWS;
  logic [8:0] cfg_data = '0;

  gmbm_req_if req_i ();
  gmbm_res_if res_i ();

  gf2_matrix_berlekamp_massey_base u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_i), .res(res_i)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gmbm_pkg::req_t pending_req[$];
  gmbm_pkg::res_t expected_res[$];
  gmbm_pkg::req_t drv_item;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   errors = 0;
  int   quiet_cycles = 0;

  // model state
  logic [63:0] e_mem[gmbm_pkg::MAX_ROWS][gmbm_pkg::MAX_COLS][gmbm_pkg::WORDS];
  logic [63:0] p_mem[gmbm_pkg::MAX_COLS][gmbm_pkg::MAX_COLS][gmbm_pkg::WORDS];
  logic [63:0] wk[gmbm_pkg::MAX_ROWS][gmbm_pkg::MAX_COLS][gmbm_pkg::WORDS];
  logic [31:0] col_deg[gmbm_pkg::MAX_COLS];
  int unsigned loc_deg[gmbm_pkg::MAX_COLS];
  logic [31:0] zrun[gmbm_pkg::MAX_COLS];
  logic [31:0] step_sum;
  logic [3:0]  rows_reg;
  logic [4:0]  cols_reg;
  logic [8:0]  len_reg;

  initial begin
    req_i.valid = 1'b0;
    req_i.mode = gmbm_pkg::MODE_WR_E;
    req_i.row = '0;
    req_i.col = '0;
    req_i.word = '0;
    req_i.data = '0;
    req_i.degree_in = '0;
    res_i.ready = 1'b0;
    foreach (e_mem[i, j, s]) e_mem[i][j][s] = '0;
    foreach (p_mem[i, j, s]) p_mem[i][j][s] = '0;
    foreach (col_deg[j]) begin
      col_deg[j] = '0;
      loc_deg[j] = 0;
      zrun[j] = '0;
    end
    step_sum = '0;
    rows_reg = 4'd1;
    cols_reg = 5'd2;
    len_reg = 9'd64;
  end

  function automatic void bm_run(output logic [1:0] st, output int unsigned done);
    int unsigned m, b, len, w, e, i, j, k, l, wp, pv;
    int s;
    logic [63:0] bitm;
    logic [1:0] modf[gmbm_pkg::MAX_COLS];
    bit found, changed, stop;
    m = rows_reg > gmbm_pkg::MAX_ROWS ? gmbm_pkg::MAX_ROWS : rows_reg;
    b = cols_reg > gmbm_pkg::MAX_COLS ? gmbm_pkg::MAX_COLS : cols_reg;
    len = len_reg > gmbm_pkg::LEN_MAX ? gmbm_pkg::LEN_MAX : len_reg;
    w = len == 0 ? 1 : (len + gmbm_pkg::WORD_BITS - 1) / gmbm_pkg::WORD_BITS;
    foreach (wk[a, c, d]) wk[a][c][d] = (a < m && c < b && d < w) ? e_mem[a][c][d] : '0;
    foreach (p_mem[a, c, d]) p_mem[a][c][d] = '0;
    for (i = 0; i < b; i++) begin
      p_mem[i][i][0] = 64'd1;
      loc_deg[i] = 0;
    end
    st = gmbm_pkg::ST_FULL;
    stop = 1'b0;
    e = 0;
    while (e < len && !stop) begin
      wp = e / gmbm_pkg::WORD_BITS;
      bitm = 64'd1 << (e % gmbm_pkg::WORD_BITS);
      changed = 1'b0;
      foreach (modf[j2]) modf[j2] = 2'b00;
      for (i = 0; i < m && !stop; i++) begin
        found = 1'b0;
        pv = 0;
        for (j = 0; j < b; j++)
          if ((wk[i][j][wp] & bitm) != 0 && (!found || col_deg[j] < col_deg[pv])) begin
            found = 1'b1;
            pv = j;
          end
        if (!found) begin
          st = gmbm_pkg::ST_NOPIV;
          stop = 1'b1;
        end else begin
          modf[pv] |= 2'b10;
          for (k = 0; k < b; k++) begin
            if (k == pv || (wk[i][k][wp] & bitm) == 0) continue;
            modf[k] |= 2'b01;
            for (l = 0; l < m; l++)
              for (s = 0; s < w; s++) wk[l][k][s] ^= wk[l][pv][s];
            for (l = 0; l < b; l++)
              for (s = 0; s < w; s++) p_mem[l][k][s] ^= p_mem[l][pv][s];
            if (loc_deg[pv] > loc_deg[k]) loc_deg[k] = loc_deg[pv];
          end
          for (l = 0; l < m; l++) begin
            for (s = w - 1; s >= 1; s--)
              wk[l][pv][s] = (wk[l][pv][s] << 1) | (wk[l][pv][s-1] >> 63);
            wk[l][pv][0] = wk[l][pv][0] << 1;
          end
          for (l = 0; l < b; l++) begin
            for (s = w - 1; s >= 1; s--)
              p_mem[l][pv][s] = (p_mem[l][pv][s] << 1) | (p_mem[l][pv][s-1] >> 63);
            p_mem[l][pv][0] = p_mem[l][pv][0] << 1;
          end
          col_deg[pv] = col_deg[pv] + 32'd1;
          if (loc_deg[pv] < gmbm_pkg::LD_MAX) loc_deg[pv]++;
        end
      end
      if (!stop) begin
        for (j = 0; j < b; j++) begin
          if (modf[j] != 0) begin
            zrun[j] = '0;
            if (modf[j][0]) changed = 1'b1;
          end else begin
            zrun[j] = zrun[j] + 32'd1;
          end
        end
        if (!changed) begin
          st = gmbm_pkg::ST_EARLY;
          stop = 1'b1;
        end else begin
          e++;
        end
      end
    end
    step_sum = step_sum + e;
    done = e;
  endfunction

  function automatic void bm_apply(gmbm_pkg::req_t it);
    gmbm_pkg::res_t r;
    logic [1:0] st;
    int unsigned done;
    r = '0;
    case (it.mode)
      gmbm_pkg::MODE_WR_E:
        if (it.row < gmbm_pkg::MAX_ROWS) e_mem[it.row[2:0]][it.col][it.word] = it.data;
      gmbm_pkg::MODE_WR_DEG: col_deg[it.col] = it.degree_in;
      gmbm_pkg::MODE_RUN: begin
        bm_run(st, done);
        r.kind = gmbm_pkg::KIND_RUN;
        r.status = st;
        r.steps = done[8:0];
        r.total_steps = step_sum;
        expected_res.insert(expected_res.size(), r);
      end
      gmbm_pkg::MODE_RD_P: begin
        r.kind = gmbm_pkg::KIND_PWORD;
        r.word_out = p_mem[it.row][it.col][it.word];
        r.total_steps = step_sum;
        expected_res.insert(expected_res.size(), r);
      end
      gmbm_pkg::MODE_RD_COL: begin
        r.kind = gmbm_pkg::KIND_COL;
        r.column_degree = col_deg[it.col];
        r.local_degree = loc_deg[it.col][8:0];
        r.zero_run = zrun[it.col];
        r.total_steps = step_sum;
        expected_res.insert(expected_res.size(), r);
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic gmbm_pkg::req_t mk(logic [2:0] mode, logic [3:0] row, logic [3:0] col,
                                        logic [1:0] word, logic [63:0] data,
                                        logic [31:0] deg);
    gmbm_pkg::req_t it;
    it.mode = mode;
    it.row = row;
    it.col = col;
    it.word = word;
    it.data = data;
    it.degree_in = deg;
    return it;
  endfunction

  task automatic queue_req(gmbm_pkg::req_t it);
    pending_req.insert(pending_req.size(), it);
  endtask

  function automatic gmbm_pkg::req_t rand_req();
    gmbm_pkg::req_t it;
    int r;
    it = mk(3'($urandom_range(7)), 4'($urandom_range(15)), 4'($urandom_range(15)),
            2'($urandom_range(3)), {$urandom, $urandom}, $urandom);
    r = $urandom_range(99);
    if (r < 35) it.mode = gmbm_pkg::MODE_WR_E;
    else if (r < 50) it.mode = gmbm_pkg::MODE_WR_DEG;
    else if (r < 60) it.mode = gmbm_pkg::MODE_RUN;
    else if (r < 78) it.mode = gmbm_pkg::MODE_RD_P;
    else if (r < 94) it.mode = gmbm_pkg::MODE_RD_COL;
    else it.mode = 3'($urandom_range(7, 5));
    r = $urandom_range(9);
    if (r == 0) it.data = '0;
    else if (r == 1) it.data = '1;
    r = $urandom_range(9);
    if (r < 6) it.degree_in = $urandom_range(6);
    else if (r == 6) it.degree_in = '1;
    if ($urandom_range(3) != 0) it.col = 4'($urandom_range(4));
    if ($urandom_range(3) != 0) it.row = 4'($urandom_range(4));
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_i.valid <= 1'b0;
    end else if (!req_i.valid || req_i.ready) begin
      if (pending_req.size() > 0 && $urandom_range(99) >= idle_pct) begin
        drv_item = pending_req.pop_front();
        req_i.mode <= drv_item.mode;
        req_i.row <= drv_item.row;
        req_i.col <= drv_item.col;
        req_i.word <= drv_item.word;
        req_i.data <= drv_item.data;
        req_i.degree_in <= drv_item.degree_in;
        req_i.valid <= 1'b1;
      end else begin
        req_i.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) res_i.ready <= !rst && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    gmbm_pkg::res_t want;
    if (!rst && req_i.valid && req_i.ready)
      bm_apply(mk(req_i.mode, req_i.row, req_i.col, req_i.word, req_i.data, req_i.degree_in));
    if (!rst && res_i.valid && res_i.ready) begin
      if (expected_res.size() == 0) begin
        flag_mismatch("unexpected result kind", 64'(res_i.kind), 64'd0);
      end else begin
        want = expected_res.pop_front();
        if (res_i.kind != want.kind)
          flag_mismatch("kind", 64'(res_i.kind), 64'(want.kind));
        if (res_i.status != want.status)
          flag_mismatch("status", 64'(res_i.status), 64'(want.status));
        if (res_i.steps != want.steps)
          flag_mismatch("steps", 64'(res_i.steps), 64'(want.steps));
        if (res_i.word_out != want.word_out)
          flag_mismatch("word_out", res_i.word_out, want.word_out);
        if (res_i.column_degree != want.column_degree)
          flag_mismatch("column_degree", 64'(res_i.column_degree), 64'(want.column_degree));
        if (res_i.local_degree != want.local_degree)
          flag_mismatch("local_degree", 64'(res_i.local_degree), 64'(want.local_degree));
        if (res_i.zero_run != want.zero_run)
          flag_mismatch("zero_run", 64'(res_i.zero_run), 64'(want.zero_run));
        if (res_i.total_steps != want.total_steps)
          flag_mismatch("total_steps", 64'(res_i.total_steps), 64'(want.total_steps));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_i.valid && req_i.ready) || (res_i.valid && res_i.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("gf2_matrix_berlekamp_massey_base regression: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_req.size() != 0 || req_i.valid || expected_res.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gmbm_pkg::CFG_ROWS: rows_reg = val[3:0];
      gmbm_pkg::CFG_COLS: cols_reg = val[4:0];
      gmbm_pkg::CFG_LEN:  len_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int rows, int cols, int len, int idle, int stall, int n);
    drain();
    cfg_write(gmbm_pkg::CFG_ROWS, 9'(rows));
    cfg_write(gmbm_pkg::CFG_COLS, 9'(cols));
    cfg_write(gmbm_pkg::CFG_LEN, 9'(len));
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) queue_req(rand_req());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // fill every E word that a later run reads: word 0 everywhere, all words of the
    // small corner used by the long runs
    for (int i = 0; i < gmbm_pkg::MAX_ROWS; i++)
      for (int j = 0; j < gmbm_pkg::MAX_COLS; j++)
        for (int s = 0; s < gmbm_pkg::WORDS; s++)
          if (s == 0 || (i < 2 && j < 3))
            queue_req(mk(gmbm_pkg::MODE_WR_E, 4'(i), 4'(j), 2'(s),
                         (i + j) % 5 == 0 ? '1 : {$urandom, $urandom}, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_P, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_COL, 4'd0, 4'd15, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_WR_DEG, 4'd0, 4'd0, 2'd0, '0, '1));
    queue_req(mk(gmbm_pkg::MODE_WR_DEG, 4'd0, 4'd1, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RUN, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_P, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_P, 4'd1, 4'd1, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_P, 4'd15, 4'd15, 2'd3, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_COL, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_COL, 4'd0, 4'd1, 2'd0, '0, '0));
    queue_req(mk(3'd5, 4'd15, 4'd15, 2'd3, '1, '1));
    queue_req(mk(3'd6, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(3'd7, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_WR_E, 4'd15, 4'd15, 2'd3, '1, '1));
    queue_req(mk(gmbm_pkg::MODE_WR_DEG, 4'd0, 4'd1, 2'd0, '0, '1));
    queue_req(mk(gmbm_pkg::MODE_RUN, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_COL, 4'd0, 4'd1, 2'd0, '0, '0));
    // no pivot in the first step
    queue_req(mk(gmbm_pkg::MODE_WR_E, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_WR_E, 4'd0, 4'd1, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RUN, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_COL, 4'd0, 4'd0, 2'd0, '0, '0));
    queue_req(mk(gmbm_pkg::MODE_RD_P, 4'd1, 4'd0, 2'd0, '0, '0));

    random_phase(1, 2, 64, 0, 0, 25);
    random_phase(2, 4, 16, 52, 0, 25);
    random_phase(0, 3, 1, 0, 52, 25);
    random_phase(3, 5, 0, 20, 20, 25);
    random_phase(15, 31, 2, 0, 0, 15);
    random_phase(1, 2, 511, 52, 0, 25);
    random_phase(4, 1, 40, 0, 52, 25);
    random_phase(2, 0, 20, 20, 20, 15);
    random_phase(8, 16, 3, 0, 0, 12);
    random_phase(2, 3, 256, 20, 20, 25);
    drain();
    if (errors == 0) begin
      $display("gf2_matrix_berlekamp_massey_base regression: pass");
    end else begin
      $display("gf2_matrix_berlekamp_massey_base regression: fail");
    end
    $finish;
  end

endmodule

@@ gf2_matrix_berlekamp_massey_base.f @@
hdl/gmbm_pkg.sv
hdl/gmbm_req_if.sv
hdl/gmbm_res_if.sv
hdl/gmbm_ctrl.sv
hdl/gmbm_dp.sv
hdl/gf2_matrix_berlekamp_massey_base.sv
hdl/gmbm_checker.sv
bench/testbench.sv
